@@ hdl/des_pkg.sv @@
// ----------------------------------------------------------------------------
// des_pkg
// Shared types and constants for the directory entry short-name search.
// ----------------------------------------------------------------------------
package des_pkg;

    localparam int unsigned ENTRY_BYTES = 32;
    localparam int unsigned NAME_BYTES  = 11;
    localparam int unsigned POS_W       = $clog2(ENTRY_BYTES);
    localparam int unsigned CFG_DATA_W  = 64;
    localparam int unsigned CFG_IDX_W   = 1;

    // entry byte offsets
    localparam logic [POS_W-1:0] POS_FIRST   = 5'd0;
    localparam logic [POS_W-1:0] POS_ATTR    = 5'd11;
    localparam logic [POS_W-1:0] POS_CLU_HI0 = 5'd20;
    localparam logic [POS_W-1:0] POS_CLU_HI1 = 5'd21;
    localparam logic [POS_W-1:0] POS_CLU_LO0 = 5'd26;
    localparam logic [POS_W-1:0] POS_CLU_LO1 = 5'd27;
    localparam logic [POS_W-1:0] POS_SIZE0   = 5'd28;
    localparam logic [POS_W-1:0] POS_LAST    = 5'd31;
    localparam logic [POS_W-1:0] POS_NAME_END = 5'd11;

    // marker bytes
    localparam logic [7:0] END_MARK       = 8'h00;
    localparam logic [7:0] DELETED_MARK   = 8'hE5;
    localparam logic [7:0] LONG_NAME_ATTR = 8'h0F;

    // result status codes
    localparam logic [1:0] ST_FOUND     = 2'd0;
    localparam logic [1:0] ST_END_MARK  = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NAME_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NAME_EXT  = 1'd1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] start_cluster;
        logic [31:0] file_size;
        logic [7:0]  attributes;
    } t_out_beat;

endpackage

@@ hdl/des_in_if.sv @@
// ----------------------------------------------------------------------------
// des_in_if
// Valid/ready channel carrying one directory byte per beat.
// ----------------------------------------------------------------------------
interface des_in_if;
    logic             valid;
    logic             ready;
    des_pkg::t_in_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/des_out_if.sv @@
// ----------------------------------------------------------------------------
// des_out_if
// Valid/ready channel carrying one search result per beat.
// ----------------------------------------------------------------------------
interface des_out_if;
    logic               valid;
    logic               ready;
    des_pkg::t_out_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/des_scan.sv @@
// ----------------------------------------------------------------------------
// des_scan
// Per-entry scan state; decides a result from the accepted byte.
// ----------------------------------------------------------------------------
module des_scan (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  des_pkg::t_in_beat     i_beat,
    input  logic [63:0]           i_name_base,
    input  logic [23:0]           i_name_ext,
    output logic                  o_res_valid,
    output des_pkg::t_out_beat    o_res
);

    logic [des_pkg::POS_W-1:0] r_pos, n_pos;
    logic                      r_match, n_match;
    logic                      r_skip, n_skip;
    logic                      r_done, n_done;
    logic [15:0]               r_clu_hi, n_clu_hi;
    logic [15:0]               r_clu_lo, n_clu_lo;
    logic [31:0]               r_size, n_size;
    logic [7:0]                r_attr, n_attr;

    logic [87:0] name;
    logic [7:0]  want;
    logic [7:0]  b;
    logic        first;
    logic        in_name;

    assign name    = {i_name_ext, i_name_base};
    assign b       = i_beat.data_byte;
    assign first   = (r_pos == des_pkg::POS_FIRST);
    assign in_name = (r_pos < des_pkg::POS_NAME_END);
    assign want    = in_name ? name[r_pos[3:0]*8 +: 8] : 8'h00;

    always_comb begin
        n_pos       = r_pos;
        n_match     = r_match;
        n_skip      = r_skip;
        n_done      = r_done;
        n_clu_hi    = r_clu_hi;
        n_clu_lo    = r_clu_lo;
        n_size      = r_size;
        n_attr      = r_attr;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (!r_done) begin
            if (first) begin
                n_match = 1'b1;
                n_skip  = 1'b0;
            end
            if (first && b == des_pkg::END_MARK) begin
                n_done      = 1'b1;
                o_res_valid = 1'b1;
                o_res.status = des_pkg::ST_END_MARK;
            end else begin
                if (first && b == des_pkg::DELETED_MARK) begin
                    n_skip = 1'b1;
                end
                if (in_name && b != want) begin
                    n_match = 1'b0;
                end
                if (r_pos == des_pkg::POS_ATTR) begin
                    n_attr = b;
                    if (b == des_pkg::LONG_NAME_ATTR) begin
                        n_skip = 1'b1;
                    end
                end
                if (r_pos == des_pkg::POS_CLU_HI0) n_clu_hi[7:0]  = b;
                if (r_pos == des_pkg::POS_CLU_HI1) n_clu_hi[15:8] = b;
                if (r_pos == des_pkg::POS_CLU_LO0) n_clu_lo[7:0]  = b;
                if (r_pos == des_pkg::POS_CLU_LO1) n_clu_lo[15:8] = b;
                if (r_pos >= des_pkg::POS_SIZE0) begin
                    n_size[r_pos[1:0]*8 +: 8] = b;
                end
                if (r_pos == des_pkg::POS_LAST && !n_skip && n_match) begin
                    n_done              = 1'b1;
                    o_res_valid         = 1'b1;
                    o_res.status        = des_pkg::ST_FOUND;
                    o_res.start_cluster = {n_clu_hi, n_clu_lo};
                    o_res.file_size     = n_size;
                    o_res.attributes    = n_attr;
                end
                n_pos = r_pos + 1'b1;
            end
        end

        if (i_beat.stream_end) begin
            if (!n_done) begin
                o_res_valid  = 1'b1;
                o_res        = '0;
                o_res.status = des_pkg::ST_NOT_FOUND;
            end
            n_pos   = '0;
            n_match = 1'b1;
            n_skip  = 1'b0;
            n_done  = 1'b0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_match <= 1'b1;
            r_skip  <= 1'b0;
            r_done  <= 1'b0;
        end else if (i_accept) begin
            r_pos   <= n_pos;
            r_match <= n_match;
            r_skip  <= n_skip;
            r_done  <= n_done;
        end
    end

    // entry fields: every one is rewritten before a match can use it
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_clu_hi <= n_clu_hi;
            r_clu_lo <= n_clu_lo;
            r_size   <= n_size;
            r_attr   <= n_attr;
        end
    end

    // a match is only decided on an entry's last byte
    a_found_at_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status == des_pkg::ST_FOUND) |-> r_pos == des_pkg::POS_LAST)
        else $error("found result away from last entry byte");

    // once decided, position stays put until the stream ends
    a_done_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && i_accept && !i_beat.stream_end) |=> (r_done && $stable(r_pos)))
        else $error("scan state moved after decision");

endmodule

@@ hdl/directory_entry_name_search.sv @@
// ----------------------------------------------------------------------------
// directory_entry_name_search
// Scans a directory byte stream for an 11-byte short name and reports the
// matching entry's cluster, size and attribute, an end marker, or not found.
// ----------------------------------------------------------------------------
//
//  channel      dir  beat contents                          handshake
//  -----------  ---  -------------------------------------  ----------
//  i_byte_ch    in   data_byte, stream_end                  valid/ready
//  o_result_ch  out  status, start_cluster, file_size, attr valid/ready
//  i_cfg_*      in   index + 64-bit data (name base / ext)  write enable
//
// One byte per cycle when not stalled. The decision for a byte is made in
// the cycle it is accepted and lands in the output register on that edge;
// results show on o_result_ch in the cycle after the byte that caused them.
// Input ready is low only while a result is held and the sink is stalled,
// so a held result never blocks a byte that causes no new result longer
// than the stall itself. Reset (synchronous, active low) clears scan control
// state, r_out_valid and both name registers; ready is low during reset.
// ----------------------------------------------------------------------------
module directory_entry_name_search (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    des_in_if.sink                              i_byte_ch,
    des_out_if.source                           o_result_ch,
    input  logic                                i_cfg_we,
    input  logic [des_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [des_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    logic [63:0]        r_name_base;
    logic [23:0]        r_name_ext;
    logic               r_out_valid;
    des_pkg::t_out_beat r_out;

    logic               in_ready;
    logic               in_acc;
    logic               res_valid;
    des_pkg::t_out_beat res;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name_base <= '0;
            r_name_ext  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                des_pkg::REG_NAME_BASE: r_name_base <= i_cfg_data[63:0];
                des_pkg::REG_NAME_EXT:  r_name_ext  <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // take a byte whenever the output slot is free or draining this cycle
    assign in_ready          = i_rst_n && (!r_out_valid || o_result_ch.ready);
    assign in_acc            = i_byte_ch.valid && in_ready;
    assign i_byte_ch.ready   = in_ready;

    des_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_acc),
        .i_beat      (i_byte_ch.data),
        .i_name_base (r_name_base),
        .i_name_ext  (r_name_ext),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_result_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && res_valid) begin
            r_out <= res;
        end
    end

    assign o_result_ch.valid = r_out_valid;
    assign o_result_ch.data  = r_out;

    // a result only appears after a byte was taken
    a_res_from_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(in_acc))
        else $error("result without accepted byte");

    // no byte is taken while a stalled result would be overwritten
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_result_ch.ready) |-> !in_acc)
        else $error("byte accepted over stalled result");

    // end marker and not-found carry zero payload
    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != des_pkg::ST_FOUND) |->
            (r_out.start_cluster == '0 && r_out.file_size == '0 &&
             r_out.attributes == '0))
        else $error("nonzero payload on non-match result");

    // status is always a defined code
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.status == des_pkg::ST_FOUND ||
                         r_out.status == des_pkg::ST_END_MARK ||
                         r_out.status == des_pkg::ST_NOT_FOUND))
        else $error("undefined status code");

endmodule
